// ----- design/lrufr_pkg.sv -----
// Package for the LRU frame replacer: sizes, request codes and the
// per-cell control struct. No dependencies.
package lrufr_pkg;

    localparam int MAX_FRAMES = 16;
    localparam int FRAME_W    = 4;
    localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
    localparam int REQ_W      = 2;

    localparam logic [REQ_W-1:0] REQ_VICTIM = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PIN    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_UNPIN  = 2'd2;

    // What each cell does on an accepted item
    typedef enum logic [2:0] {
        CELL_HOLD,    // no change
        CELL_VICTIM,  // every cell takes its right neighbor (drop oldest)
        CELL_PIN,     // cells at or right of the matching cell shift left
        CELL_APPEND,  // first empty cell takes the new frame
        CELL_ROLL     // drop oldest, new frame lands in the last used cell
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic [FRAME_W-1:0] ins_frame;
    } t_cell_ctl;

endpackage

// ----- design/lrufr_if.sv -----
// Handshake interfaces for request and response items.
// Depends on lrufr_pkg.
interface lrufr_req_if;
    logic                           valid;
    logic                           ready;
    logic [lrufr_pkg::REQ_W-1:0]    req_type;
    logic [lrufr_pkg::FRAME_W-1:0]  frame;

    modport source (output valid, output req_type, output frame, input ready);
    modport sink   (input valid, input req_type, input frame, output ready);
endinterface

interface lrufr_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           found;
    logic [lrufr_pkg::FRAME_W-1:0]  victim_frame;
    logic [lrufr_pkg::CNT_W-1:0]    entry_count;

    modport source (output valid, output found, output victim_frame,
                    output entry_count, input ready);
    modport sink   (input valid, input found, input victim_frame,
                    input entry_count, output ready);
endinterface

// ----- design/lrufr_cell.sv -----
// One slot of the recency list: a frame id and an occupied bit.
// Shifts left from its right neighbor or loads a new frame. Depends on lrufr_pkg.
module lrufr_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lrufr_pkg::t_cell_ctl            i_ctl,
    input  logic [lrufr_pkg::FRAME_W-1:0]   i_key,
    input  logic [lrufr_pkg::FRAME_W-1:0]   i_nbr_frame,
    input  logic                            i_nbr_valid,
    input  logic                            i_prev_valid,
    input  logic                            i_prev_hit,
    output logic [lrufr_pkg::FRAME_W-1:0]   o_frame,
    output logic                            o_valid,
    output logic                            o_hit
);

    logic [lrufr_pkg::FRAME_W-1:0] r_frame, n_frame;
    logic                          r_valid, n_valid;
    logic                          w_shift;
    logic                          w_insert;

    // hit propagates rightward: set in the matching cell and all after it
    assign o_hit   = i_prev_hit | (r_valid && (r_frame == i_key));
    assign o_frame = r_frame;
    assign o_valid = r_valid;

    always_comb begin
        w_shift  = 1'b0;
        w_insert = 1'b0;
        unique case (i_ctl.op)
            lrufr_pkg::CELL_VICTIM: w_shift = 1'b1;
            lrufr_pkg::CELL_PIN:    w_shift = o_hit;
            lrufr_pkg::CELL_APPEND: w_insert = !r_valid && i_prev_valid;
            lrufr_pkg::CELL_ROLL: begin
                w_shift  = 1'b1;
                w_insert = r_valid && !i_nbr_valid;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_frame = r_frame;
        n_valid = r_valid;
        if (w_insert) begin
            n_frame = i_ctl.ins_frame;
            n_valid = 1'b1;
        end else if (w_shift) begin
            n_frame = i_nbr_frame;
            n_valid = i_nbr_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_frame <= n_frame;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

// ----- design/lru_frame_replacer.sv -----
// Top level of the LRU frame replacer: request decode, entry count,
// row of lrufr_cell slots and the response register. Depends on lrufr_pkg, lrufr_if.
//
// Usage:
//   i_req carries one request item: req_type (0 victim, 1 pin, 2 unpin) and
//   frame. o_rsp returns exactly one item per request: found, victim_frame
//   and entry_count after the step.
//   i_cfg_we / i_cfg_wdata write the capacity register (reset 16); write it
//   only while no request is in flight. Capacity 0 acts as 1, above 16 as 16.
//   Latency: the response is valid the cycle after the request is accepted.
//   Throughput: one request per cycle unless a held response stalls it.
//   Matching, removal and insertion happen in the same cycle across the row
//   of 16 slots, each slot shifting from its right neighbor; the ripple of
//   the match flag along the row sets the critical path.
//   A stalled response holds in its register; a new request is still taken
//   in the cycle the held response is consumed.
//   Reset (synchronous, active low) empties the list and drops any response.
module lru_frame_replacer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lrufr_pkg::CNT_W-1:0]     i_cfg_wdata,
    lrufr_req_if.sink                       i_req,
    lrufr_rsp_if.source                     o_rsp
);

    localparam int N = lrufr_pkg::MAX_FRAMES;

    logic [lrufr_pkg::CNT_W-1:0]   r_cap;
    logic [lrufr_pkg::CNT_W-1:0]   r_count, n_count;
    logic                          r_out_valid;
    logic                          r_found, n_found;
    logic [lrufr_pkg::FRAME_W-1:0] r_victim, n_victim;
    logic [lrufr_pkg::CNT_W-1:0]   r_out_count;

    logic                          w_accept;
    logic [lrufr_pkg::CNT_W-1:0]   w_eff_cap;
    logic                          w_full;
    logic                          w_any_hit;
    lrufr_pkg::t_cell_ctl          w_ctl;

    logic [lrufr_pkg::FRAME_W-1:0] w_frame [N];
    logic                          w_valid [N];
    logic                          w_hit   [N];

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;

    always_comb begin
        if (r_cap == '0) begin
            w_eff_cap = lrufr_pkg::CNT_W'(1);
        end else if (r_cap > lrufr_pkg::CNT_W'(N)) begin
            w_eff_cap = lrufr_pkg::CNT_W'(N);
        end else begin
            w_eff_cap = r_cap;
        end
    end

    assign w_full    = (r_count >= w_eff_cap);
    assign w_any_hit = w_hit[N-1];

    // Request decode: cell operation, next count and response fields
    always_comb begin
        w_ctl.op        = lrufr_pkg::CELL_HOLD;
        w_ctl.ins_frame = i_req.frame;
        n_count         = r_count;
        n_found         = 1'b0;
        n_victim        = '0;
        if (w_accept) begin
            unique case (i_req.req_type)
                lrufr_pkg::REQ_VICTIM: begin
                    if (r_count != '0) begin
                        w_ctl.op = lrufr_pkg::CELL_VICTIM;
                        n_count  = r_count - lrufr_pkg::CNT_W'(1);
                        n_found  = 1'b1;
                        n_victim = w_frame[0];
                    end
                end
                lrufr_pkg::REQ_PIN: begin
                    if (w_any_hit) begin
                        w_ctl.op = lrufr_pkg::CELL_PIN;
                        n_count  = r_count - lrufr_pkg::CNT_W'(1);
                    end
                end
                lrufr_pkg::REQ_UNPIN: begin
                    if (!w_any_hit) begin
                        if (w_full) begin
                            w_ctl.op = lrufr_pkg::CELL_ROLL;
                        end else begin
                            w_ctl.op = lrufr_pkg::CELL_APPEND;
                            n_count  = r_count + lrufr_pkg::CNT_W'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            logic [lrufr_pkg::FRAME_W-1:0] w_nbr_frame;
            logic                          w_nbr_valid;
            logic                          w_prev_valid;
            logic                          w_prev_hit;

            if (g == N - 1) begin : g_last
                assign w_nbr_frame = '0;
                assign w_nbr_valid = 1'b0;
            end else begin : g_mid
                assign w_nbr_frame = w_frame[g+1];
                assign w_nbr_valid = w_valid[g+1];
            end

            if (g == 0) begin : g_first
                assign w_prev_valid = 1'b1;
                assign w_prev_hit   = 1'b0;
            end else begin : g_rest
                assign w_prev_valid = w_valid[g-1];
                assign w_prev_hit   = w_hit[g-1];
            end

            lrufr_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_key        (i_req.frame),
                .i_nbr_frame  (w_nbr_frame),
                .i_nbr_valid  (w_nbr_valid),
                .i_prev_valid (w_prev_valid),
                .i_prev_hit   (w_prev_hit),
                .o_frame      (w_frame[g]),
                .o_valid      (w_valid[g]),
                .o_hit        (w_hit[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= lrufr_pkg::CNT_W'(N);
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_found     <= n_found;
            r_victim    <= n_victim;
            r_out_count <= n_count;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.found        = r_found;
    assign o_rsp.victim_frame = r_victim;
    assign o_rsp.entry_count  = r_out_count;

endmodule
